FILE: rtl/core/bmpu_pkg.sv
package bmpu_pkg;

   // Default palette depth and the width of the pixel depth field.
   localparam int PALETTE_DEPTH_DEFAULT = 256;
   localparam int BPP_WIDTH = 6;

   // Configuration register indexes.
   localparam logic CSR_BITS_PER_PIXEL = 1'b0;
   localparam logic CSR_PLAIN_RGB_16   = 1'b1;

   // Pixel depths that the block understands.
   localparam logic [BPP_WIDTH-1:0] BPP_1  = 6'd1;
   localparam logic [BPP_WIDTH-1:0] BPP_2  = 6'd2;
   localparam logic [BPP_WIDTH-1:0] BPP_4  = 6'd4;
   localparam logic [BPP_WIDTH-1:0] BPP_8  = 6'd8;
   localparam logic [BPP_WIDTH-1:0] BPP_16 = 6'd16;
   localparam logic [BPP_WIDTH-1:0] BPP_24 = 6'd24;
   localparam logic [BPP_WIDTH-1:0] BPP_32 = 6'd32;

   // Input operation codes.
   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_DATA = 1'b1;

   typedef struct packed {
      logic       operation;
      logic [7:0] palette_slot;
      logic [7:0] load_blue;
      logic [7:0] load_green;
      logic [7:0] load_red;
      logic [7:0] data_byte;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] blue;
      logic [7:0] green;
      logic [7:0] red;
      logic       last_of_run;
   } rsp_payload_type;

   typedef struct packed {
      logic [BPP_WIDTH-1:0] bits_per_pixel;
      logic                 plain_rgb_16;
   } cfg_type;

   // Work classes handed from the front to the back.
   typedef enum logic [1:0] {
      KIND_LOAD    = 2'd0,
      KIND_PALETTE = 2'd1,
      KIND_DIRECT  = 2'd2
   } entry_kind_type;

   // One queue entry. The color holds blue low and red high; a palette
   // byte travels in the low byte of the color.
   typedef struct packed {
      entry_kind_type kind;
      logic [7:0]     slot;
      logic [23:0]    color;
   } entry_type;

   typedef struct packed {
      logic busy;
      logic issue;
   } back_status_type;

endpackage

FILE: rtl/core/bmpu_front.sv
module bmpu_front (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_write_enable,
   input  logic                     csr_index,
   input  logic [5:0]               csr_write_data,
   input  logic                     accept,
   input  bmpu_pkg::req_payload_type req_payload,
   output logic                     push,
   output bmpu_pkg::entry_type      push_entry,
   output bmpu_pkg::cfg_type        cfg
);
   import bmpu_pkg::*;

   cfg_type     cfg_ff, cfg_in;
   logic [1:0]  phase_ff, phase_in;
   logic [23:0] held_ff, held_in;

   logic        palette_mode;
   logic        direct_mode;
   logic [2:0]  need;
   logic        complete;
   logic [7:0]  d;
   logic [23:0] pixel;

   assign cfg = cfg_ff;
   assign d = req_payload.data_byte;

   // Classify the current depth.
   always_comb begin
      palette_mode = 1'b0;
      direct_mode = 1'b0;
      need = 3'd1;
      case (cfg_ff.bits_per_pixel)
         BPP_1, BPP_2, BPP_4, BPP_8: begin
            palette_mode = 1'b1;
         end
         BPP_16: begin
            direct_mode = 1'b1;
            need = 3'd2;
         end
         BPP_24: begin
            direct_mode = 1'b1;
            need = 3'd3;
         end
         BPP_32: begin
            direct_mode = 1'b1;
            need = 3'd4;
         end
         default: begin
            palette_mode = 1'b0;
         end
      endcase
   end

   // A multi-byte pixel is complete on the byte that reaches the needed count.
   assign complete = ({1'b0, phase_ff} + 3'd1) >= need;

   // Assemble the finished direct pixel from the held bytes and this byte.
   always_comb begin
      case (cfg_ff.bits_per_pixel)
         BPP_16: begin
            pixel = {{d[6:2], 3'b000}, {d[1:0], held_ff[7:5], 3'b000},
                     {held_ff[4:0], 3'b000}};
         end
         BPP_24: begin
            pixel = {d, held_ff[15:0]};
         end
         default: begin
            pixel = held_ff;
         end
      endcase
   end

   // Next state of the configuration and of the byte assembly.
   always_comb begin
      cfg_in = cfg_ff;
      phase_in = phase_ff;
      held_in = held_ff;
      push = 1'b0;
      push_entry.kind = KIND_LOAD;
      push_entry.slot = req_payload.palette_slot;
      push_entry.color = {req_payload.load_red, req_payload.load_green,
                          req_payload.load_blue};
      if (csr_write_enable) begin
         case (csr_index)
            CSR_BITS_PER_PIXEL: begin
               cfg_in.bits_per_pixel = csr_write_data;
               phase_in = 2'd0;
               held_in = 24'd0;
            end
            CSR_PLAIN_RGB_16: begin
               cfg_in.plain_rgb_16 = csr_write_data[0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
      if (accept) begin
         if (req_payload.operation == OP_LOAD) begin
            push = 1'b1;
         end else if (palette_mode) begin
            push = 1'b1;
            push_entry.kind = KIND_PALETTE;
            push_entry.color = {16'd0, d};
         end else if (direct_mode) begin
            if (!complete) begin
               case (phase_ff)
                  2'd0: held_in = {held_ff[23:8], d};
                  2'd1: held_in = {held_ff[23:16], d, held_ff[7:0]};
                  default: held_in = {d, held_ff[15:0]};
               endcase
               phase_in = phase_ff + 2'd1;
            end else begin
               phase_in = 2'd0;
               held_in = 24'd0;
               push = !(cfg_ff.bits_per_pixel == BPP_16 && !cfg_ff.plain_rgb_16);
               push_entry.kind = KIND_DIRECT;
               push_entry.color = pixel;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.bits_per_pixel <= BPP_24;
         cfg_ff.plain_rgb_16 <= 1'b1;
         phase_ff <= 2'd0;
         held_ff <= 24'd0;
      end else begin
         cfg_ff <= cfg_in;
         phase_ff <= phase_in;
         held_ff <= held_in;
      end
   end

endmodule

FILE: rtl/core/bmpu_queue.sv
module bmpu_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  bmpu_pkg::entry_type push_entry,
   input  logic                pop,
   output logic                full,
   output logic                head_valid,
   output bmpu_pkg::entry_type head,
   output logic [1:0]          count
);
   import bmpu_pkg::*;

   entry_type  slots_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign full = count_ff == 2'd2;
   assign head_valid = count_ff != 2'd0;
   assign head = slots_ff[rd_ptr_ff];
   assign count = count_ff;

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   // Entry storage needs no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

FILE: rtl/core/bmpu_back.sv
module bmpu_back #(
   parameter int PALETTE_DEPTH = bmpu_pkg::PALETTE_DEPTH_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  bmpu_pkg::cfg_type         cfg,
   input  logic                      head_valid,
   input  bmpu_pkg::entry_type       head,
   output logic                      pop,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output bmpu_pkg::rsp_payload_type rsp_payload,
   output bmpu_pkg::back_status_type status
);
   import bmpu_pkg::*;

   localparam int AW = $clog2(PALETTE_DEPTH);
   localparam logic [8:0] DEPTH_LIMIT = 9'(PALETTE_DEPTH);

   logic [23:0] palette_mem [PALETTE_DEPTH];

   logic        busy_ff, busy_in;
   logic [7:0]  sr_ff, sr_in;
   logic [3:0]  remain_ff, remain_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [23:0] rd_data_ff;
   logic        is_direct_ff;
   logic        zero_ff;
   logic        last_ff;
   logic [23:0] direct_ff;

   logic        advance;
   logic [7:0]  cur_sr;
   logic [3:0]  cur_remain;
   logic [3:0]  fields_init;
   logic [7:0]  index;
   logic [7:0]  shifted;
   logic        is_last;
   logic        head_palette;
   logic        issue_pal;
   logic        issue_dir;
   logic        do_load;
   logic [23:0] color;

   // The output register may take a new pixel when empty or being drained.
   assign advance = !rsp_valid_ff || rsp_ready;

   assign cur_sr = busy_ff ? sr_ff : head.color[7:0];
   assign cur_remain = busy_ff ? remain_ff : fields_init;
   assign is_last = cur_remain == 4'd1;

   // Field count, current index and remaining bits for the palette depth.
   always_comb begin
      case (cfg.bits_per_pixel)
         BPP_1: begin
            fields_init = 4'd8;
            index = {7'd0, cur_sr[7]};
            shifted = {cur_sr[6:0], 1'b0};
         end
         BPP_2: begin
            fields_init = 4'd4;
            index = {6'd0, cur_sr[7:6]};
            shifted = {cur_sr[5:0], 2'b00};
         end
         BPP_4: begin
            fields_init = 4'd2;
            index = {4'd0, cur_sr[7:4]};
            shifted = {cur_sr[3:0], 4'd0};
         end
         default: begin
            fields_init = 4'd1;
            index = cur_sr;
            shifted = 8'd0;
         end
      endcase
   end

   // Work selection: a palette byte keeps the back busy until its last pixel.
   assign head_palette = head_valid && head.kind == KIND_PALETTE;
   assign issue_pal = advance && (busy_ff || head_palette);
   assign issue_dir = advance && !busy_ff && head_valid && head.kind == KIND_DIRECT;
   assign do_load = !busy_ff && head_valid && head.kind == KIND_LOAD;
   assign pop = do_load || issue_dir || (issue_pal && !busy_ff);

   always_comb begin
      busy_in = busy_ff;
      sr_in = sr_ff;
      remain_in = remain_ff;
      if (issue_pal) begin
         busy_in = !is_last;
         sr_in = shifted;
         remain_in = cur_remain - 4'd1;
      end
      rsp_valid_in = advance ? (issue_pal || issue_dir) : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Shift state and output side information.
   always_ff @(posedge clock) begin
      sr_ff <= sr_in;
      remain_ff <= remain_in;
      if (advance) begin
         is_direct_ff <= issue_dir;
         zero_ff <= {1'b0, index} >= DEPTH_LIMIT;
         last_ff <= issue_dir || is_last;
         direct_ff <= head.color;
      end
   end

   // Palette memory: written by loads, read once per palette pixel.
   always_ff @(posedge clock) begin
      if (do_load && {1'b0, head.slot} < DEPTH_LIMIT) begin
         palette_mem[head.slot[AW-1:0]] <= head.color;
      end
      if (issue_pal) begin
         rd_data_ff <= palette_mem[index[AW-1:0]];
      end
   end

   // Pick the pixel color for the output.
   always_comb begin
      if (is_direct_ff) begin
         color = direct_ff;
      end else if (zero_ff) begin
         color = 24'd0;
      end else begin
         color = rd_data_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_payload.blue = color[7:0];
   assign rsp_payload.green = color[15:8];
   assign rsp_payload.red = color[23:16];
   assign rsp_payload.last_of_run = last_ff;
   assign status.busy = busy_ff;
   assign status.issue = issue_pal || issue_dir;

endmodule

FILE: rtl/core/bitmap_pixel_unpacker.sv
// Bitmap pixel unpacker.
// Request items carry either a palette load (operation 0) or one pixel data
// byte (operation 1) on req_valid/req_ready; pixels leave as blue, green, red
// and last_of_run on rsp_valid/rsp_ready. The csr_ port sets the pixel depth
// and the 16 bit uncompressed flag; the user must write it only while the
// block is idle, and the block does not enforce this. The front takes one
// item per cycle whenever the two-entry queue has room, assembles multi-byte
// pixels and sorts items into loads, palette bytes and direct pixels. The
// back carries them out in order: a load writes the palette, a palette byte
// yields 8/bits_per_pixel pixels, one memory read each. The first result of
// an item passes the queue, then the output register. With the receiver
// ready, the block sustains one item per cycle in 16, 24 and 32 bit modes
// and one pixel per cycle in palette modes, set by the single read port.
// Reset clears the queue, the output register and the byte assembly and sets
// the depth to 24 bits with 16 bit data uncompressed; the palette holds
// nothing defined until loaded. When the receiver stalls, the output register
// holds its pixel, the back waits, and the queue fills before req_ready drops.
module bitmap_pixel_unpacker #(
   parameter int PALETTE_DEPTH = bmpu_pkg::PALETTE_DEPTH_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_write_enable,
   input  logic                      csr_index,
   input  logic [5:0]                csr_write_data,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  bmpu_pkg::req_payload_type req_payload,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output bmpu_pkg::rsp_payload_type rsp_payload
);
   import bmpu_pkg::*;

   logic            accept;
   logic            push;
   entry_type       push_entry;
   cfg_type         cfg;
   logic            pop;
   logic            full;
   logic            head_valid;
   entry_type       head;
   logic [1:0]      count;
   back_status_type status;

   assign req_ready = !full;
   assign accept = req_valid && req_ready;

   bmpu_front u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .accept           (accept),
      .req_payload      (req_payload),
      .push             (push),
      .push_entry       (push_entry),
      .cfg              (cfg)
   );

   bmpu_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .full       (full),
      .head_valid (head_valid),
      .head       (head),
      .count      (count)
   );

   bmpu_back #(
      .PALETTE_DEPTH (PALETTE_DEPTH)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .head_valid  (head_valid),
      .head        (head),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .status      (status)
   );

   // The queue never holds more than its two entries.
   assert property (@(posedge clock) disable iff (reset) count != 2'd3)
      else $error("queue count out of range");

   // A pixel that is not the last of its byte means the back is still busy.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.last_of_run |-> status.busy)
      else $error("non-final pixel without a busy back");

   // The back only pops when the queue has an entry.
   assert property (@(posedge clock) disable iff (reset) pop |-> head_valid)
      else $error("pop from an empty queue");

   // A new pixel is issued only into a free or draining output register.
   assert property (@(posedge clock) disable iff (reset)
      status.issue && rsp_valid && !rsp_ready |-> 1'b0)
      else $error("pixel issued over a stalled result");

endmodule

FILE: sim/bitmap_pixel_unpacker_tb.sv
`timescale 1ns / 100ps

module bitmap_pixel_unpacker_tb;
   import bmpu_pkg::*;

   localparam int RANDOM_ITEMS   = 100;
   localparam int QUIET_CYCLES   = 12;
   localparam int DRAIN_CYCLES   = 20;
   localparam int HOLD_CYCLES    = 80;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int REPORT_LIMIT   = 20;

   // One row of the directed stimulus: a register write or an item.
   typedef enum logic {ROW_CSR, ROW_ITEM} row_kind_type;

   typedef struct {
      row_kind_type    kind;
      logic            csr_index;
      logic [5:0]      csr_value;
      req_payload_type item;
      bit              typed;
      rsp_payload_type pixel;
   } plan_row_type;

   logic            clock            = 1'b0;
   logic            reset            = 1'b1;
   logic            csr_write_enable = 1'b0;
   logic            csr_index        = CSR_BITS_PER_PIXEL;
   logic [5:0]      csr_write_data   = '0;
   logic            req_valid        = 1'b0;
   logic            req_ready;
   req_payload_type req_payload      = '0;
   logic            rsp_valid;
   logic            rsp_ready        = 1'b0;
   rsp_payload_type rsp_payload;

   // Shadow copy of the block's palette, byte assembly and settings.
   logic [23:0] palette_colors [256];
   logic [1:0]  bytes_held;
   logic [23:0] held_word;
   logic [5:0]  depth_setting;
   logic        plain16_setting;

   // Pixels caused by the latest item, and pixels still owed by the block.
   rsp_payload_type fresh_pixels [8];
   int              fresh_count;
   rsp_payload_type awaited_pixels [$];
   plan_row_type    plan [$];

   int mismatch_count = 0;
   int items_sent     = 0;
   int pixels_checked = 0;
   int stalled_cycles = 0;
   int send_gap_max   = 6;
   int take_gap_max   = 6;
   bit hold_wanted    = 1'b0;
   bit hold_done      = 1'b0;

   bitmap_pixel_unpacker dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_payload      (req_payload),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_payload      (rsp_payload)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Watchdog: the run ends if no item moves on either channel for too long.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stalled_cycles = 0;
      end else begin
         stalled_cycles++;
      end
      if (stalled_cycles == WATCHDOG_LIMIT) begin
         $display("Timeout: no handshake for %0d cycles, %0d pixels still owed.",
                  WATCHDOG_LIMIT, awaited_pixels.size());
         $display("FAIL");
         $finish;
      end
   end

   task automatic report_mismatch(input string what);
      if (mismatch_count < REPORT_LIMIT) begin
         $display("Mismatch at %0t: %s", $realtime, what);
      end
      mismatch_count++;
   endtask

   // Work out the pixels that one accepted item causes and update the shadow state.
   task automatic unpack_to_pixels(input req_payload_type item);
      int          width;
      int          fields;
      int          need;
      logic [7:0]  index;
      logic [7:0]  first;
      logic [23:0] color;
      fresh_count = 0;
      if (item.operation == OP_LOAD) begin
         palette_colors[item.palette_slot] = {item.load_red, item.load_green, item.load_blue};
         return;
      end
      case (depth_setting)
         BPP_1, BPP_2, BPP_4, BPP_8: begin
            // Palette modes: most significant field first, one pixel per field.
            width = int'(depth_setting);
            fields = 8 / width;
            for (int k = 0; k < fields; k++) begin
               index = 8'((item.data_byte >> (8 - (k + 1) * width)) & ((1 << width) - 1));
               color = palette_colors[index];
               fresh_pixels[k] = '{blue: color[7:0], green: color[15:8],
                                   red: color[23:16], last_of_run: (k == fields - 1)};
            end
            fresh_count = fields;
         end
         BPP_16, BPP_24, BPP_32: begin
            need = int'(depth_setting) / 8;
            if (int'(bytes_held) + 1 < need) begin
               held_word[8 * bytes_held +: 8] = item.data_byte;
               bytes_held = bytes_held + 2'd1;
            end else begin
               first = held_word[7:0];
               if (depth_setting == BPP_16) begin
                  // Packed 5:5:5, emitted only for uncompressed data.
                  if (plain16_setting) begin
                     fresh_pixels[0] = '{blue: {first[4:0], 3'b000},
                                         green: {item.data_byte[1:0], first[7:5], 3'b000},
                                         red: {item.data_byte[6:2], 3'b000},
                                         last_of_run: 1'b1};
                     fresh_count = 1;
                  end
               end else if (depth_setting == BPP_24) begin
                  fresh_pixels[0] = '{blue: held_word[7:0], green: held_word[15:8],
                                      red: item.data_byte, last_of_run: 1'b1};
                  fresh_count = 1;
               end else begin
                  // The fourth byte of a 32 bit pixel is dropped.
                  fresh_pixels[0] = '{blue: held_word[7:0], green: held_word[15:8],
                                      red: held_word[23:16], last_of_run: 1'b1};
                  fresh_count = 1;
               end
               bytes_held = '0;
               held_word = '0;
            end
         end
         default: begin
         end
      endcase
   endtask

   // Offer one item, wait for it to be taken, then record what it owes.
   task automatic send_item(input req_payload_type item, input bit typed,
                            input rsp_payload_type pixel);
      int gap;
      gap = (send_gap_max == 0) ? 0 : $urandom_range(0, send_gap_max);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      unpack_to_pixels(item);
      if (typed) begin
         awaited_pixels.push_back(pixel);
      end else begin
         for (int k = 0; k < fresh_count; k++) awaited_pixels.push_back(fresh_pixels[k]);
      end
      items_sent++;
      @(negedge clock);
   endtask

   // Let the block drain, including items that cause no pixel.
   task automatic settle();
      req_valid <= 1'b0;
      while (awaited_pixels.size() != 0) @(negedge clock);
      repeat (QUIET_CYCLES) @(negedge clock);
   endtask

   task automatic write_register(input logic index, input logic [5:0] value);
      settle();
      csr_write_enable <= 1'b1;
      csr_index <= index;
      csr_write_data <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      @(negedge clock);
      if (index == CSR_BITS_PER_PIXEL) begin
         depth_setting = value;
         bytes_held = '0;
         held_word = '0;
      end else begin
         plain16_setting = value[0];
      end
   endtask

   function automatic req_payload_type data_item(input logic [7:0] data);
      req_payload_type item;
      item.operation = OP_DATA;
      item.palette_slot = 8'($urandom);
      item.load_blue = 8'($urandom);
      item.load_green = 8'($urandom);
      item.load_red = 8'($urandom);
      item.data_byte = data;
      return item;
   endfunction

   function automatic req_payload_type load_item(input logic [7:0] slot,
                                                 input logic [23:0] color);
      req_payload_type item;
      item.operation = OP_LOAD;
      item.palette_slot = slot;
      item.load_blue = color[7:0];
      item.load_green = color[15:8];
      item.load_red = color[23:16];
      item.data_byte = 8'($urandom);
      return item;
   endfunction

   function automatic rsp_payload_type pixel(input logic [7:0] blue, input logic [7:0] green,
                                             input logic [7:0] red);
      return '{blue: blue, green: green, red: red, last_of_run: 1'b1};
   endfunction

   function automatic void add_csr(input logic index, input logic [5:0] value);
      plan_row_type row;
      row.kind = ROW_CSR;
      row.csr_index = index;
      row.csr_value = value;
      row.item = '0;
      row.typed = 1'b0;
      row.pixel = '0;
      plan.push_back(row);
   endfunction

   function automatic void add_item(input req_payload_type item, input bit typed,
                                    input rsp_payload_type want);
      plan_row_type row;
      row.kind = ROW_ITEM;
      row.csr_index = CSR_BITS_PER_PIXEL;
      row.csr_value = '0;
      row.item = item;
      row.typed = typed;
      row.pixel = want;
      plan.push_back(row);
   endfunction

   // Receiver: random stalls, one long hold-off on request, and the pixel check.
   initial begin
      rsp_payload_type want;
      int gap;
      wait (reset === 1'b0);
      @(negedge clock);
      forever begin
         gap = (take_gap_max == 0) ? 0 : $urandom_range(0, take_gap_max);
         if (hold_wanted && !hold_done) begin
            hold_done = 1'b1;
            gap = HOLD_CYCLES;
         end
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         if (awaited_pixels.size() == 0) begin
            report_mismatch($sformatf("unexpected pixel %h", rsp_payload));
         end else begin
            want = awaited_pixels.pop_front();
            if (rsp_payload.blue !== want.blue)
               report_mismatch($sformatf("pixel %0d blue %h, expected %h",
                                         pixels_checked, rsp_payload.blue, want.blue));
            if (rsp_payload.green !== want.green)
               report_mismatch($sformatf("pixel %0d green %h, expected %h",
                                         pixels_checked, rsp_payload.green, want.green));
            if (rsp_payload.red !== want.red)
               report_mismatch($sformatf("pixel %0d red %h, expected %h",
                                         pixels_checked, rsp_payload.red, want.red));
            if (rsp_payload.last_of_run !== want.last_of_run)
               report_mismatch($sformatf("pixel %0d last_of_run %b, expected %b",
                                         pixels_checked, rsp_payload.last_of_run,
                                         want.last_of_run));
            pixels_checked++;
         end
         @(negedge clock);
      end
   end

   // Stimulus: palette fill, directed rows, then random phases of settings.
   initial begin
      logic [5:0]      depth_choices [7];
      logic [5:0]      new_depth;
      logic [23:0]     color;
      req_payload_type item;
      int              phase;
      int              counted;
      int              burst;
      int              pick;
      bit              ignored;

      depth_choices = '{BPP_1, BPP_2, BPP_4, BPP_8, BPP_16, BPP_24, BPP_32};
      bytes_held = '0;
      held_word = '0;
      depth_setting = BPP_24;
      plain16_setting = 1'b1;

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Fill every palette entry so that no byte can read an unwritten one.
      for (int slot = 0; slot < 256; slot++) begin
         if (slot == 0) color = 24'h000000;
         else if (slot == 255) color = 24'hFFFFFF;
         else color = 24'($urandom);
         send_item(load_item(8'(slot), color), 1'b0, '0);
      end

      // Directed rows. The block comes out of reset in 24 bit mode.
      add_item(data_item(8'hFF), 1'b0, '0);
      add_item(data_item(8'hFF), 1'b0, '0);
      add_item(data_item(8'hFF), 1'b1, pixel(8'hFF, 8'hFF, 8'hFF));
      // A load in the middle of a pixel keeps the bytes gathered so far.
      add_item(data_item(8'h00), 1'b0, '0);
      add_item(load_item(8'd7, 24'h563412), 1'b0, '0);
      add_item(data_item(8'h00), 1'b0, '0);
      add_item(data_item(8'h00), 1'b1, pixel(8'h00, 8'h00, 8'h00));
      add_csr(CSR_BITS_PER_PIXEL, BPP_32);
      add_item(data_item(8'h44), 1'b0, '0);
      add_item(data_item(8'h55), 1'b0, '0);
      add_item(data_item(8'h66), 1'b0, '0);
      add_item(data_item(8'h77), 1'b1, pixel(8'h44, 8'h55, 8'h66));
      add_csr(CSR_BITS_PER_PIXEL, BPP_16);
      add_item(data_item(8'hFF), 1'b0, '0);
      add_item(data_item(8'hFF), 1'b1, pixel(8'hF8, 8'hF8, 8'hF8));
      // Compressed 16 bit data advances the byte count but emits nothing.
      add_csr(CSR_PLAIN_RGB_16, 6'd0);
      add_item(data_item(8'h12), 1'b0, '0);
      add_item(data_item(8'h34), 1'b0, '0);
      add_csr(CSR_PLAIN_RGB_16, 6'd1);
      add_csr(CSR_BITS_PER_PIXEL, BPP_1);
      add_item(data_item(8'hA5), 1'b0, '0);
      add_csr(CSR_BITS_PER_PIXEL, BPP_2);
      add_item(data_item(8'h1B), 1'b0, '0);
      add_csr(CSR_BITS_PER_PIXEL, BPP_4);
      add_item(data_item(8'hF0), 1'b0, '0);
      add_csr(CSR_BITS_PER_PIXEL, BPP_8);
      add_item(data_item(8'hFF), 1'b1, pixel(8'hFF, 8'hFF, 8'hFF));
      add_item(data_item(8'h00), 1'b1, pixel(8'h00, 8'h00, 8'h00));
      // Unsupported depths swallow data bytes.
      add_csr(CSR_BITS_PER_PIXEL, 6'd0);
      add_item(data_item(8'h5A), 1'b0, '0);
      add_csr(CSR_BITS_PER_PIXEL, 6'd63);
      add_item(data_item(8'hC3), 1'b0, '0);
      // Rewriting the depth drops a partly gathered pixel.
      add_csr(CSR_BITS_PER_PIXEL, BPP_24);
      add_item(data_item(8'hAA), 1'b0, '0);
      add_csr(CSR_BITS_PER_PIXEL, BPP_24);
      add_item(data_item(8'h01), 1'b0, '0);
      add_item(data_item(8'h02), 1'b0, '0);
      add_item(data_item(8'h03), 1'b1, pixel(8'h01, 8'h02, 8'h03));

      foreach (plan[i]) begin
         if (plan[i].kind == ROW_CSR) write_register(plan[i].csr_index, plan[i].csr_value);
         else send_item(plan[i].item, plan[i].typed, plan[i].pixel);
      end

      // Random phases, each with its own depth, flag and idling pattern.
      phase = 0;
      counted = 0;
      while (counted < RANDOM_ITEMS) begin
         ignored = 1'b0;
         if (phase == 2) begin
            new_depth = BPP_1;
         end else if ($urandom_range(0, 9) == 0) begin
            do new_depth = 6'($urandom_range(0, 63));
            while (new_depth inside {BPP_1, BPP_2, BPP_4, BPP_8, BPP_16, BPP_24, BPP_32});
            ignored = 1'b1;
         end else begin
            new_depth = depth_choices[$urandom_range(0, 6)];
         end
         write_register(CSR_BITS_PER_PIXEL, new_depth);
         write_register(CSR_PLAIN_RGB_16, {5'd0, ($urandom_range(0, 3) != 0)});

         pick = $urandom_range(0, 3);
         send_gap_max = (pick == 0) ? 0 : (pick == 1) ? 6 : $urandom_range(1, 6);
         pick = $urandom_range(0, 3);
         take_gap_max = (pick == 0) ? 0 : (pick == 1) ? 6 : $urandom_range(1, 6);
         // One early 1 bit phase meets a long receiver stall and backs up the input.
         if (phase == 2) hold_wanted = 1'b1;

         burst = ignored ? 6 : $urandom_range(15, 40);
         repeat (burst) begin
            if ($urandom_range(0, 9) == 0) item = load_item(8'($urandom), 24'($urandom));
            else item = data_item(8'($urandom));
            send_item(item, 1'b0, '0);
            if (!ignored) counted++;
         end
         phase++;
      end

      settle();
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("Covered palette depths 1, 2, 4 and 8, direct depths 16, 24 and 32,");
      $display("compressed 16 bit and unsupported depths: %0d items, %0d pixels, %0d mismatches.",
               items_sent, pixels_checked, mismatch_count);
      if (mismatch_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

FILE: bitmap_pixel_unpacker.f
rtl/core/bmpu_pkg.sv
rtl/core/bmpu_front.sv
rtl/core/bmpu_queue.sv
rtl/core/bmpu_back.sv
rtl/core/bitmap_pixel_unpacker.sv
sim/bitmap_pixel_unpacker_tb.sv
